@@ design/i2crm_pkg.sv @@
package i2crm_pkg;

    localparam int REG_DEPTH_DEFAULT = 16;
    localparam logic [7:0] FILL_BYTE = 8'hFF;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [2:0] {
        KIND_ADDR_WRITE = 3'd0,
        KIND_ADDR_READ  = 3'd1,
        KIND_BYTE_RX    = 3'd2,
        KIND_BYTE_TX    = 3'd3,
        KIND_BUS_ERROR  = 3'd4,
        KIND_HOST_WRITE = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        REG_IDX_COUNT    = 2'd0,
        REG_IDX_WRITABLE = 2'd1,
        REG_IDX_STATUS   = 2'd2,
        REG_IDX_ERRMASK  = 2'd3
    } reg_idx_t;

    localparam logic [4:0] RST_REGISTER_COUNT    = 5'd16;
    localparam logic [7:0] RST_WRITABLE_ADDRESS  = 8'd6;
    localparam logic [7:0] RST_STATUS_ADDRESS    = 8'd4;
    localparam logic [7:0] RST_ERROR_BIT_MASK    = 8'd1;

    typedef struct packed {
        logic [4:0] register_count;
        logic [7:0] writable_address;
        logic [7:0] status_address;
        logic [7:0] error_bit_mask;
    } cfg_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] byte_in;
        logic [7:0] host_address;
        logic       error_is_nack;
    } item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic [7:0] pointer_now;
    } result_t;

endpackage

@@ design/i2c_register_map_slave_unit.sv @@
// Register-map side of an I2C slave, fed one bus event per transfer on the s_ channel
// and answering each with one result transfer on the m_ channel. Sustained rate is one
// event per cycle while m_ready is high; a taken event passes through the input register,
// then the result register, the pointer, first-byte flag and register store being updated
// as its result is registered. A stalled m_ready holds the event in the input register.
// The register store is flip-flops, cleared at reset.
// Configuration registers sit on the APB port at byte addresses 0x0 (register count),
// 0x4 (writable address), 0x8 (status address) and 0xC (error bit mask); write them only
// while no event is in flight.
module i2c_register_map_slave_unit
    import i2crm_pkg::*;
#(
    parameter int REG_DEPTH = REG_DEPTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [2:0]            s_kind,
    input  logic [7:0]            s_byte_in,
    input  logic [7:0]            s_host_address,
    input  logic                  s_error_is_nack,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_tx_byte,
    output logic                  m_tx_valid,
    output logic [7:0]            m_pointer_now,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    result_t core_result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    advance;
    logic    s_take;

    // an event moves on when the result register is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    assign in_valid_next  = s_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg.kind          <= s_kind;
            in_item_reg.byte_in       <= s_byte_in;
            in_item_reg.host_address  <= s_host_address;
            in_item_reg.error_is_nack <= s_error_is_nack;
        end
        if (advance) begin
            out_reg <= core_result;
        end
    end

    i2crm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    i2crm_core #(
        .REG_DEPTH (REG_DEPTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    assign m_valid       = out_valid_reg;
    assign m_tx_byte     = out_reg.tx_byte;
    assign m_tx_valid    = out_reg.tx_valid;
    assign m_pointer_now = out_reg.pointer_now;

endmodule

@@ design/i2crm_cfg.sv @@
module i2crm_cfg
    import i2crm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_IDX_COUNT:    cfg_next.register_count   = pwdata[4:0];
                REG_IDX_WRITABLE: cfg_next.writable_address = pwdata[7:0];
                REG_IDX_STATUS:   cfg_next.status_address   = pwdata[7:0];
                REG_IDX_ERRMASK:  cfg_next.error_bit_mask   = pwdata[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_IDX_COUNT:    prdata = APB_DATA_W'(cfg_reg.register_count);
            REG_IDX_WRITABLE: prdata = APB_DATA_W'(cfg_reg.writable_address);
            REG_IDX_STATUS:   prdata = APB_DATA_W'(cfg_reg.status_address);
            REG_IDX_ERRMASK:  prdata = APB_DATA_W'(cfg_reg.error_bit_mask);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.register_count   <= RST_REGISTER_COUNT;
            cfg_reg.writable_address <= RST_WRITABLE_ADDRESS;
            cfg_reg.status_address   <= RST_STATUS_ADDRESS;
            cfg_reg.error_bit_mask   <= RST_ERROR_BIT_MASK;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ design/i2crm_core.sv @@
module i2crm_core
    import i2crm_pkg::*;
#(
    parameter int REG_DEPTH = REG_DEPTH_DEFAULT
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step_en,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    localparam int IDX_W = (REG_DEPTH > 1) ? $clog2(REG_DEPTH) : 1;
    localparam logic [8:0] DEPTH9 = 9'(REG_DEPTH);

    logic [7:0] store_reg [REG_DEPTH];
    logic [7:0] ptr_reg;
    logic [7:0] ptr_next;
    logic       expect_reg;
    logic       expect_next;

    logic [8:0] count9;
    logic [8:0] live9;
    logic       ptr_in_range;
    logic       next_in_range;
    logic [7:0] ptr_inc;
    logic [7:0] rd_byte;

    logic       wr_en;
    logic [7:0] wr_addr;
    logic [7:0] wr_data;
    logic [7:0] wr_bits;

    assign count9        = 9'(cfg.register_count);
    assign live9         = (count9 > DEPTH9) ? DEPTH9 : count9;
    assign ptr_in_range  = {1'b0, ptr_reg} < live9;
    assign next_in_range = {1'b0, ptr_next} < live9;
    assign ptr_inc       = ptr_in_range ? ptr_reg + 8'd1 : ptr_reg;

    // in range implies below the depth, so the index is inside the store
    assign rd_byte = next_in_range ? store_reg[ptr_next[IDX_W-1:0]] : FILL_BYTE;

    always_comb begin
        ptr_next        = ptr_reg;
        expect_next     = expect_reg;
        wr_en           = 1'b0;
        wr_addr         = item.host_address;
        wr_data         = item.byte_in;
        wr_bits         = 8'hFF;
        result.tx_byte  = 8'd0;
        result.tx_valid = 1'b0;
        unique case (kind_t'(item.kind))
            KIND_ADDR_WRITE: begin
                expect_next = 1'b1;
            end
            KIND_ADDR_READ: begin
                result.tx_byte  = rd_byte;
                result.tx_valid = 1'b1;
            end
            KIND_BYTE_RX: begin
                if (expect_reg) begin
                    ptr_next    = item.byte_in;
                    expect_next = 1'b0;
                end else begin
                    ptr_next = ptr_inc;
                    wr_addr  = ptr_reg;
                    wr_en    = ptr_in_range && (ptr_reg == cfg.writable_address);
                end
            end
            KIND_BYTE_TX: begin
                ptr_next        = ptr_inc;
                result.tx_byte  = rd_byte;
                result.tx_valid = 1'b1;
            end
            KIND_BUS_ERROR: begin
                // touch only the masked bits: set on a real error, clear on a nack
                wr_addr = cfg.status_address;
                wr_data = {8{~item.error_is_nack}};
                wr_bits = cfg.error_bit_mask;
                wr_en   = {1'b0, cfg.status_address} < DEPTH9;
            end
            KIND_HOST_WRITE: begin
                wr_en = {1'b0, item.host_address} < DEPTH9;
            end
            default: begin
                ptr_next = ptr_reg;
            end
        endcase
        result.pointer_now = ptr_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg    <= 8'd0;
            expect_reg <= 1'b1;
        end else if (step_en) begin
            ptr_reg    <= ptr_next;
            expect_reg <= expect_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int e = 0; e < REG_DEPTH; e++) begin
                store_reg[e] <= 8'd0;
            end
        end else if (step_en && wr_en) begin
            for (int e = 0; e < REG_DEPTH; e++) begin
                if (wr_addr == 8'(e)) begin
                    store_reg[e] <= (store_reg[e] & ~wr_bits) | (wr_data & wr_bits);
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_hold_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !step_en |=> $stable(ptr_reg) && $stable(expect_reg))
        else $error("pointer state changed without a step");

    a_addr_write_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && (item.kind == KIND_ADDR_WRITE) |=> expect_reg)
        else $error("address-write event did not arm the pointer byte");

    a_data_step: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && (item.kind == KIND_BYTE_RX) && !expect_reg
        |=> (ptr_reg == $past(ptr_reg)) || (ptr_reg == $past(ptr_reg) + 8'd1))
        else $error("data byte moved the pointer by more than one");

    a_tx_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        result.tx_valid |-> (item.kind == KIND_ADDR_READ) || (item.kind == KIND_BYTE_TX))
        else $error("transmit byte offered for a non-transmit event");
`endif

endmodule
